FILE: src/thrs_pkg.sv
// shared constants and types of the track hit region selector
// no dependencies; used by the hit and configuration interfaces and the top level
package thrs_pkg;

	// photodetector geometry
	localparam int CHAN_PER_DET = 128;
	localparam int CHAN_HALF    = CHAN_PER_DET / 2;
	localparam int CH_W         = 7;
	localparam int DET_IDX_W    = 2;

	// register widths
	localparam int CNT_W      = 8;
	localparam int MAT_W      = 9;
	localparam int DET_EDGE_W = 7;
	localparam int DIE_W      = 7;
	localparam int SUM_W      = MAT_W + 1;

	// configuration port
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = MAT_W;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MIN_C_SIDE      = 3'd0,
		REG_MIN_A_SIDE      = 3'd1,
		REG_MIN_TOP_HALF    = 3'd2,
		REG_MIN_BOTTOM_HALF = 3'd3,
		REG_MIN_TOTAL       = 3'd4,
		REG_EXCL_MAT_EDGE   = 3'd5,
		REG_EXCL_DET_EDGE   = 3'd6,
		REG_EXCL_DIE_CENTER = 3'd7
	} cfg_reg_t;

	// per-track hit counters
	typedef struct packed {
		logic [CNT_W-1:0] c_side;
		logic [CNT_W-1:0] a_side;
		logic [CNT_W-1:0] top;
		logic [CNT_W-1:0] bottom;
		logic [CNT_W-1:0] total;
	} counts_t;

	// hit item as held in the input stage
	typedef struct packed {
		logic                 is_ours;
		logic                 side;
		logic                 in_top;
		logic                 in_bottom;
		logic [DET_IDX_W-1:0] detector_index;
		logic [CH_W-1:0]      channel;
		logic                 base_ok;
		logic                 last;
	} hit_t;

endpackage

FILE: src/thrs_hit_if.sv
// hit item channel: valid, ready and one hit's fields
// depends on thrs_pkg
interface thrs_hit_if import thrs_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic                 is_ours;
	logic                 side;
	logic                 in_top;
	logic                 in_bottom;
	logic [DET_IDX_W-1:0] detector_index;
	logic [CH_W-1:0]      channel;
	logic                 base_ok;
	logic                 last;

	modport source (output valid, is_ours, side, in_top, in_bottom, detector_index, channel,
		base_ok, last, input ready);
	modport sink (input valid, is_ours, side, in_top, in_bottom, detector_index, channel,
		base_ok, last, output ready);
endinterface

FILE: src/thrs_res_if.sv
// result item channel: valid, ready and the track verdict
// no package dependency
interface thrs_res_if;
	logic valid;
	logic ready;
	logic accept;
	logic hit_excluded;

	modport source (output valid, accept, hit_excluded, input ready);
	modport sink (input valid, accept, hit_excluded, output ready);
endinterface

FILE: src/thrs_cfg_if.sv
// configuration write channel: valid, ready, register index and data
// depends on thrs_pkg
interface thrs_cfg_if import thrs_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

FILE: src/track_hit_region_selector_unit.sv
// top level of the track hit region selector
// depends on thrs_pkg, thrs_hit_if, thrs_res_if and thrs_cfg_if
//
// Takes one hit per item and emits one verdict item on each item marked last.
// Each hit is first captured in an input register; while it is held there the
// exclusion windows are checked, and as it leaves the saturating per-track
// counters are updated or, on the last item, the verdict is compared on the
// updated counts, loaded into the result register and the counters cleared.
// One item is taken every cycle; the only stall comes from a last item meeting
// a result register whose previous verdict is not yet taken. A hit reaches
// the counters as it leaves the input register; a last item's verdict is loaded
// at that edge and offered on the result channel. Configuration writes are
// always taken and should only be issued while no track is open.
module track_hit_region_selector_unit import thrs_pkg::*; (
	input  logic           clk,
	input  logic           arst_n,
	thrs_hit_if.sink       hit,
	thrs_res_if.source     result,
	thrs_cfg_if.sink       cfg
);

	// configuration registers
	logic [CNT_W-1:0]      min_c_q, min_a_q, min_top_q, min_bot_q, min_all_q;
	logic [MAT_W-1:0]      excl_mat_q;
	logic [DET_EDGE_W-1:0] excl_det_q;
	logic [DIE_W-1:0]      excl_die_q;

	// input stage
	logic  hit_valid_s1;
	hit_t  hit_s1;

	// track state
	counts_t counts_q;
	logic    excl_seen_q;

	// result register
	logic res_valid_q;
	logic res_accept_q;
	logic res_excl_q;

	logic    s1_advance;
	logic    res_load;
	logic    excluded;
	logic    excl_next;
	counts_t counts_next;
	logic    verdict;

	// widened operands for window compares
	logic [SUM_W-1:0] ch_w;
	logic [SUM_W-1:0] mat_w;
	logic [SUM_W-1:0] rest_w;
	logic [SUM_W-1:0] det_w;
	logic [SUM_W-1:0] die_w;
	logic [SUM_W-1:0] full_w;
	logic [SUM_W-1:0] half_w;
	logic             mat_hit, edge_hit, die_hit;

	function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
		sat_inc = (v == {CNT_W{1'b1}}) ? v : v + 1'b1;
	endfunction

	// configuration writes
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_c_q    <= '0;
			min_a_q    <= '0;
			min_top_q  <= '0;
			min_bot_q  <= '0;
			min_all_q  <= '0;
			excl_mat_q <= '0;
			excl_det_q <= '0;
			excl_die_q <= '0;
		end else if (cfg.valid) begin
			case (cfg_reg_t'(cfg.index))
				REG_MIN_C_SIDE:      min_c_q    <= cfg.data[CNT_W-1:0];
				REG_MIN_A_SIDE:      min_a_q    <= cfg.data[CNT_W-1:0];
				REG_MIN_TOP_HALF:    min_top_q  <= cfg.data[CNT_W-1:0];
				REG_MIN_BOTTOM_HALF: min_bot_q  <= cfg.data[CNT_W-1:0];
				REG_MIN_TOTAL:       min_all_q  <= cfg.data[CNT_W-1:0];
				REG_EXCL_MAT_EDGE:   excl_mat_q <= cfg.data[MAT_W-1:0];
				REG_EXCL_DET_EDGE:   excl_det_q <= cfg.data[DET_EDGE_W-1:0];
				REG_EXCL_DIE_CENTER: excl_die_q <= cfg.data[DIE_W-1:0];
				default: ;
			endcase
		end
	end

	// handshake: the input stage moves on unless a last item must wait for
	// the result register to drain
	assign s1_advance = hit_valid_s1 && !(hit_s1.last && res_valid_q && !result.ready);
	assign hit.ready  = !hit_valid_s1 || s1_advance;
	assign res_load   = s1_advance && hit_s1.last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_valid_s1 <= 1'b0;
		end else if (hit.ready) begin
			hit_valid_s1 <= hit.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (hit.valid && hit.ready) begin
			hit_s1.is_ours        <= hit.is_ours;
			hit_s1.side           <= hit.side;
			hit_s1.in_top         <= hit.in_top;
			hit_s1.in_bottom      <= hit.in_bottom;
			hit_s1.detector_index <= hit.detector_index;
			hit_s1.channel        <= hit.channel;
			hit_s1.base_ok        <= hit.base_ok;
			hit_s1.last           <= hit.last;
		end
	end

	// exclusion windows, all compares widened to SUM_W so that none wraps
	always_comb begin
		ch_w   = SUM_W'(hit_s1.channel);
		mat_w  = SUM_W'(excl_mat_q);
		det_w  = SUM_W'(excl_det_q);
		die_w  = SUM_W'(excl_die_q);
		full_w = SUM_W'(CHAN_PER_DET);
		half_w = SUM_W'(CHAN_HALF);
		rest_w = mat_w - full_w;

		// mat edge: past one photodetector width the outer ones are gone
		// entirely and the rest eats into the inner ones
		mat_hit = 1'b0;
		if (mat_w >= full_w) begin
			case (hit_s1.detector_index)
				2'd0, 2'd3: mat_hit = 1'b1;
				2'd1:       mat_hit = ch_w < rest_w;
				2'd2:       mat_hit = (ch_w + rest_w >= full_w) && (rest_w != '0);
				default:    mat_hit = 1'b0;
			endcase
		end else if (mat_w != '0) begin
			case (hit_s1.detector_index)
				2'd0:    mat_hit = ch_w < mat_w;
				2'd3:    mat_hit = ch_w + mat_w >= full_w;
				default: mat_hit = 1'b0;
			endcase
		end

		// both edges of every photodetector
		edge_hit = (det_w != '0) && ((ch_w < det_w) || (ch_w + det_w >= full_w));

		// gap around the die centre
		die_hit = (die_w != '0) &&
			(((ch_w < half_w) && (ch_w + die_w >= half_w)) ||
			 ((ch_w >= half_w) && (ch_w - half_w < die_w)));

		excluded = mat_hit || edge_hit || die_hit;
	end

	// counter update and verdict
	always_comb begin
		counts_next = counts_q;
		excl_next   = excl_seen_q;
		if (hit_s1.is_ours) begin
			if (excluded) begin
				excl_next = 1'b1;
			end else begin
				if (hit_s1.side) begin
					counts_next.a_side = sat_inc(counts_q.a_side);
				end else begin
					counts_next.c_side = sat_inc(counts_q.c_side);
				end
				if (hit_s1.in_top) begin
					counts_next.top = sat_inc(counts_q.top);
				end
				if (hit_s1.in_bottom) begin
					counts_next.bottom = sat_inc(counts_q.bottom);
				end
				counts_next.total = sat_inc(counts_q.total);
			end
		end
		verdict = !excl_next &&
			(counts_next.c_side >= min_c_q) &&
			(counts_next.a_side >= min_a_q) &&
			(counts_next.top >= min_top_q) &&
			(counts_next.bottom >= min_bot_q) &&
			(counts_next.total >= min_all_q) &&
			hit_s1.base_ok;
	end

	// track state, cleared after each last item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			counts_q    <= '0;
			excl_seen_q <= 1'b0;
		end else if (s1_advance) begin
			if (hit_s1.last) begin
				counts_q    <= '0;
				excl_seen_q <= 1'b0;
			end else begin
				counts_q    <= counts_next;
				excl_seen_q <= excl_next;
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (res_load) begin
			res_valid_q <= 1'b1;
		end else if (result.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			res_accept_q <= verdict;
			res_excl_q   <= excl_next;
		end
	end

	assign result.valid        = res_valid_q;
	assign result.accept       = res_accept_q;
	assign result.hit_excluded = res_excl_q;

endmodule
